FILE: hw/rtl/whps_pkg.sv
// ----------------------------------------------------------------------------
// whps_pkg
// Shared types, parse phases, status codes and header tags for the audio
// file header sniffer and parser.
// ----------------------------------------------------------------------------
package whps_pkg;

    // one input byte of the file
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    // one status result
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] file_rate;
        logic        rate_mismatch;
    } out_item_t;

    // result handed from the parse core to the result register
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

    // parse phases
    typedef enum logic [3:0] {
        PH_MAGIC     = 4'd0,
        PH_RIFFLEN   = 4'd1,
        PH_WAVE      = 4'd2,
        PH_FMTID     = 4'd3,
        PH_FMTLEN    = 4'd4,
        PH_FORMAT    = 4'd5,
        PH_CHANNELS  = 4'd6,
        PH_RATE      = 4'd7,
        PH_AVG       = 4'd8,
        PH_ALIGN     = 4'd9,
        PH_BITS      = 4'd10,
        PH_FMTSKIP   = 4'd11,
        PH_CHUNKID   = 4'd12,
        PH_CHUNKLEN  = 4'd13,
        PH_CHUNKSKIP = 4'd14,
        PH_IDLE      = 4'd15
    } phase_t;

    // status codes
    typedef enum logic [3:0] {
        ST_WAV_OK    = 4'd0,
        ST_RAW       = 4'd1,
        ST_NIST      = 4'd2,
        ST_OGG       = 4'd3,
        ST_FLAC      = 4'd4,
        ST_MP3       = 4'd5,
        ST_NOT_WAVE  = 4'd6,
        ST_NO_FMT    = 4'd7,
        ST_NOT_PCM   = 4'd8,
        ST_NOT_MONO  = 4'd9,
        ST_NOT_16BIT = 4'd10,
        ST_TRUNCATED = 4'd11
    } status_t;

    // four-byte tags as read little-endian, first byte in the low bits
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_NIST = 32'h5453_494E;
    localparam logic [31:0] TAG_OGGS = 32'h5367_674F;
    localparam logic [31:0] TAG_FLAC = 32'h4361_4C66;

    // mp3 prefix bytes
    localparam logic [15:0] MP3_LOW   = 16'hFFFF;
    localparam logic [7:0]  MP3_THIRD = 8'hFF;
    localparam logic [7:0]  MP3_ALT   = 8'hFE;

    // required fmt values
    localparam logic [31:0] FMT_PCM      = 32'd1;
    localparam logic [31:0] FMT_MONO     = 32'd1;
    localparam logic [31:0] FMT_BITS     = 32'd16;
    localparam logic [31:0] FMT_STD_LEN  = 32'd16;

endpackage

FILE: hw/rtl/whps_in_stage.sv
// ----------------------------------------------------------------------------
// whps_in_stage
// Input register: holds one byte until the parse core can take it.
// ----------------------------------------------------------------------------
module whps_in_stage
    import whps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     down_ready,
    output logic     step,
    output in_item_t item
);

    logic     valid_reg;
    in_item_t item_reg;
    logic     load;

    // hand the held byte on when the result side has room
    assign step     = valid_reg & down_ready;
    assign in_stall = valid_reg & ~down_ready;
    assign load     = in_valid & ~in_stall;
    assign item     = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (step)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_data;
        end
    end

endmodule

FILE: hw/rtl/whps_parse_core.sv
// ----------------------------------------------------------------------------
// whps_parse_core
// Parser state and the per-byte update: field assembly, tag and value
// checks, chunk skipping and the status decision.
// ----------------------------------------------------------------------------
module whps_parse_core
    import whps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  in_item_t    item,
    input  logic [31:0] expected_rate,
    output result_t     result
);

    phase_t      phase_reg,     phase_next;
    logic [1:0]  byte_cnt_reg,  byte_cnt_next;
    logic [31:0] shift_reg,     shift_next;
    logic [31:0] skip_reg,      skip_next;
    logic [31:0] fmt_len_reg,   fmt_len_next;
    logic [31:0] rate_reg,      rate_next;
    logic        decided_reg,   decided_next;
    logic        pad_reg,       pad_next;
    logic        seen_reg,      seen_next;
    logic        is_data_reg,   is_data_next;

    logic [31:0] field_val;
    logic [1:0]  cnt_inc;
    logic        two_byte;
    logic        in_skip;
    logic        in_field;
    logic        field_done;
    logic        emit_field;
    logic        emit;
    status_t     st_code;
    logic [31:0] out_rate;

    // field assembly
    always_comb
    begin
        field_val = shift_reg | ({24'd0, item.data_byte} << {byte_cnt_reg, 3'b000});
        cnt_inc   = byte_cnt_reg + 2'd1;
        two_byte  = (phase_reg == PH_FORMAT) || (phase_reg == PH_CHANNELS) ||
                    (phase_reg == PH_ALIGN) || (phase_reg == PH_BITS);
        in_skip   = !decided_reg &&
                    ((phase_reg == PH_FMTSKIP) || (phase_reg == PH_CHUNKSKIP));
        in_field  = !decided_reg && !in_skip && (phase_reg != PH_IDLE);
        field_done = in_field && (cnt_inc == (two_byte ? 2'd2 : 2'd0));
    end

    // status decision
    always_comb
    begin
        emit_field = 1'b0;
        st_code    = ST_TRUNCATED;
        if (field_done)
        begin
            case (phase_reg)
                PH_MAGIC:
                begin
                    if (field_val != TAG_RIFF)
                    begin
                        emit_field = 1'b1;
                        if (field_val == TAG_NIST)
                            st_code = ST_NIST;
                        else if (field_val == TAG_OGGS)
                            st_code = ST_OGG;
                        else if (field_val == TAG_FLAC)
                            st_code = ST_FLAC;
                        else if (field_val[15:0] == MP3_LOW &&
                                 (field_val[23:16] == MP3_THIRD ||
                                  field_val[23:16] == MP3_ALT))
                            st_code = ST_MP3;
                        else
                            st_code = ST_RAW;
                    end
                end
                PH_WAVE:
                begin
                    if (field_val != TAG_WAVE)
                    begin
                        emit_field = 1'b1;
                        st_code    = ST_NOT_WAVE;
                    end
                end
                PH_FMTID:
                begin
                    if (field_val != TAG_FMT)
                    begin
                        emit_field = 1'b1;
                        st_code    = ST_NO_FMT;
                    end
                end
                PH_FORMAT:
                begin
                    if (field_val != FMT_PCM)
                    begin
                        emit_field = 1'b1;
                        st_code    = ST_NOT_PCM;
                    end
                end
                PH_CHANNELS:
                begin
                    if (field_val != FMT_MONO)
                    begin
                        emit_field = 1'b1;
                        st_code    = ST_NOT_MONO;
                    end
                end
                PH_BITS:
                begin
                    if (field_val != FMT_BITS)
                    begin
                        emit_field = 1'b1;
                        st_code    = ST_NOT_16BIT;
                    end
                end
                PH_CHUNKLEN:
                begin
                    if (is_data_reg)
                    begin
                        emit_field = 1'b1;
                        st_code    = ST_WAV_OK;
                    end
                end
                default:
                begin
                    emit_field = 1'b0;
                end
            endcase
        end
        // end of stream before any decision reports truncation
        emit = emit_field ||
               (item.end_of_stream && !decided_reg && (phase_reg != PH_IDLE));
    end

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        byte_cnt_next = byte_cnt_reg;
        shift_next    = shift_reg;
        skip_next     = skip_reg;
        fmt_len_next  = fmt_len_reg;
        rate_next     = rate_reg;
        decided_next  = decided_reg;
        pad_next      = pad_reg;
        seen_next     = seen_reg;
        is_data_next  = is_data_reg;

        if (in_skip)
        begin
            if (skip_reg != 32'd0)
                skip_next = skip_reg - 32'd1;
            else
                pad_next = 1'b0;
            if (skip_next == 32'd0 && !pad_next)
                phase_next = PH_CHUNKID;
        end
        else if (in_field)
        begin
            shift_next    = field_val;
            byte_cnt_next = cnt_inc;
            if (field_done)
            begin
                byte_cnt_next = 2'd0;
                shift_next    = 32'd0;
                case (phase_reg)
                    PH_MAGIC:    phase_next = PH_RIFFLEN;
                    PH_RIFFLEN:  phase_next = PH_WAVE;
                    PH_WAVE:     phase_next = PH_FMTID;
                    PH_FMTID:    phase_next = PH_FMTLEN;
                    PH_FMTLEN:
                    begin
                        fmt_len_next = field_val;
                        phase_next   = PH_FORMAT;
                    end
                    PH_FORMAT:   phase_next = PH_CHANNELS;
                    PH_CHANNELS: phase_next = PH_RATE;
                    PH_RATE:
                    begin
                        rate_next  = field_val;
                        seen_next  = 1'b1;
                        phase_next = PH_AVG;
                    end
                    PH_AVG:      phase_next = PH_ALIGN;
                    PH_ALIGN:    phase_next = PH_BITS;
                    PH_BITS:
                    begin
                        // extra fmt bytes plus pad when the length is odd
                        if (fmt_len_reg > FMT_STD_LEN)
                        begin
                            skip_next  = fmt_len_reg - FMT_STD_LEN;
                            pad_next   = fmt_len_reg[0];
                            phase_next = PH_FMTSKIP;
                        end
                        else
                        begin
                            phase_next = PH_CHUNKID;
                        end
                    end
                    PH_CHUNKID:
                    begin
                        is_data_next = (field_val == TAG_DATA);
                        phase_next   = PH_CHUNKLEN;
                    end
                    PH_CHUNKLEN:
                    begin
                        skip_next  = field_val;
                        pad_next   = field_val[0];
                        phase_next = (field_val == 32'd0) ? PH_CHUNKID : PH_CHUNKSKIP;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
        else if (!decided_reg)
        begin
            decided_next = 1'b1;
        end

        if (emit)
        begin
            decided_next = 1'b1;
            phase_next   = PH_IDLE;
        end

        // restart after the last byte of a file
        if (item.end_of_stream)
        begin
            phase_next    = PH_MAGIC;
            byte_cnt_next = 2'd0;
            shift_next    = 32'd0;
            skip_next     = 32'd0;
            fmt_len_next  = 32'd0;
            rate_next     = 32'd0;
            decided_next  = 1'b0;
            pad_next      = 1'b0;
            seen_next     = 1'b0;
            is_data_next  = 1'b0;
        end
    end

    // result fields, rate as it stands after this byte
    always_comb
    begin
        if (field_done && phase_reg == PH_RATE)
            out_rate = field_val;
        else
            out_rate = seen_reg ? rate_reg : 32'd0;
        result.valid              = step & emit;
        result.item.status        = st_code;
        result.item.file_rate     = out_rate;
        result.item.rate_mismatch = ((field_done && phase_reg == PH_RATE) || seen_reg) &&
                                    (expected_rate != 32'd0) &&
                                    (expected_rate != out_rate);
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC;
            byte_cnt_reg <= 2'd0;
            shift_reg    <= 32'd0;
            skip_reg     <= 32'd0;
            fmt_len_reg  <= 32'd0;
            rate_reg     <= 32'd0;
            decided_reg  <= 1'b0;
            pad_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            is_data_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            byte_cnt_reg <= byte_cnt_next;
            shift_reg    <= shift_next;
            skip_reg     <= skip_next;
            fmt_len_reg  <= fmt_len_next;
            rate_reg     <= rate_next;
            decided_reg  <= decided_next;
            pad_reg      <= pad_next;
            seen_reg     <= seen_next;
            is_data_reg  <= is_data_next;
        end
    end

endmodule

FILE: hw/rtl/whps_out_stage.sv
// ----------------------------------------------------------------------------
// whps_out_stage
// Result register: holds one status result until the sink takes it.
// ----------------------------------------------------------------------------
module whps_out_stage
    import whps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  result_t   result,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      valid_reg;
    out_item_t data_reg;

    // room when empty or when the held result transfers this cycle
    assign can_load  = ~valid_reg | ~out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= result.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (can_load && result.valid)
        begin
            data_reg <= result.item;
        end
    end

endmodule

FILE: hw/rtl/wav_header_sniff_parser.sv
// ----------------------------------------------------------------------------
// wav_header_sniff_parser
// Byte-serial sniffer for audio file magics with a WAVE/fmt header parser
// that reports one status result per file.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    in_item_t  (byte, end mark)
//  out       source     out_valid / out_stall  out_item_t (status, rate, flag)
//  cfg       sink       cfg_valid / cfg_ready  32-bit expected rate
//
//  one byte per cycle while no result is stalled; a byte goes through the
//  input register and the parse step into the result register, so out_valid
//  rises when the result register takes the result of the deciding byte.
//  reset clears the parser to the magic phase and the expected rate to zero.
//  a stalled result holds the parse step; an empty input register still takes
//  one more byte, then in_stall rises. cfg_ready is always high.
// ----------------------------------------------------------------------------
module wav_header_sniff_parser
    import whps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0] expected_rate_reg;
    logic        can_load;
    logic        step;
    in_item_t    item;
    result_t     result;

    assign cfg_ready = 1'b1;

    // expected rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_rate_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            expected_rate_reg <= cfg_data;
        end
    end

    // input register
    whps_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .down_ready (can_load),
        .step       (step),
        .item       (item)
    );

    // parse step
    whps_parse_core u_parse_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (item),
        .expected_rate (expected_rate_reg),
        .result        (result)
    );

    // result register
    whps_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: tb/wav_header_sniff_parser_tb.sv
// ----------------------------------------------------------------------------
// wav_header_sniff_parser_tb
// Drives audio files into the header sniffer one byte at a time, with random
// gaps and output stalls. A byte-level model of the parser in this bench
// predicts each status transfer, and the checker compares it field by field.
// The files include each magic, WAVE headers with and without faults,
// truncated files and random noise, under several expected-rate settings.
// ----------------------------------------------------------------------------
module wav_header_sniff_parser_tb;
    import whps_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // predicted status transfers, oldest first
    out_item_t   status_q[$];
    // bytes of the file being built
    logic [7:0]  file_q[$];

    int unsigned fail_count;
    int unsigned status_seen;
    int unsigned bytes_sent;
    int unsigned burst_left;
    int unsigned hold_cycles;
    bit          gaps_on;

    // parser model state
    phase_t      pr_phase;
    int unsigned pr_pos;
    logic [31:0] pr_shift;
    logic [31:0] pr_skip;
    logic [31:0] pr_fmt_len;
    logic [31:0] pr_rate;
    logic [31:0] pr_expected_rate;
    bit          pr_decided;
    bit          pr_pad;
    bit          pr_rate_seen;
    bit          pr_is_data;

    wav_header_sniff_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------

    function automatic void parser_restart();
        pr_phase     = PH_MAGIC;
        pr_pos       = 0;
        pr_shift     = '0;
        pr_skip      = '0;
        pr_fmt_len   = '0;
        pr_rate      = '0;
        pr_decided   = 1'b0;
        pr_pad       = 1'b0;
        pr_rate_seen = 1'b0;
        pr_is_data   = 1'b0;
    endfunction

    // queue one status and stop parsing this file
    function automatic void report_status(status_t st);
        out_item_t item;
        item.status        = st;
        item.file_rate     = pr_rate_seen ? pr_rate : 32'd0;
        item.rate_mismatch = pr_rate_seen && pr_expected_rate != 0
                             && pr_expected_rate != pr_rate;
        status_q.push_back(item);
        pr_decided = 1'b1;
        pr_phase   = PH_IDLE;
    endfunction

    function automatic void begin_skip(logic [31:0] count, bit pad);
        pr_skip  = count;
        pr_pad   = pad;
        pr_phase = (count == 0 && !pad) ? PH_CHUNKID : PH_CHUNKSKIP;
    endfunction

    function automatic int unsigned field_len(phase_t ph);
        if (ph == PH_FORMAT || ph == PH_CHANNELS || ph == PH_ALIGN || ph == PH_BITS)
            return 2;
        return 4;
    endfunction

    // act on one complete little-endian field
    function automatic void take_field(logic [31:0] v);
        case (pr_phase)
            PH_MAGIC:
            begin
                if (v == TAG_RIFF)
                    pr_phase = PH_RIFFLEN;
                else if (v == TAG_NIST)
                    report_status(ST_NIST);
                else if (v == TAG_OGGS)
                    report_status(ST_OGG);
                else if (v == TAG_FLAC)
                    report_status(ST_FLAC);
                else if (v[15:0] == MP3_LOW
                         && (v[23:16] == MP3_THIRD || v[23:16] == MP3_ALT))
                    report_status(ST_MP3);
                else
                    report_status(ST_RAW);
            end
            PH_RIFFLEN: pr_phase = PH_WAVE;
            PH_WAVE:
            begin
                if (v != TAG_WAVE)
                    report_status(ST_NOT_WAVE);
                else
                    pr_phase = PH_FMTID;
            end
            PH_FMTID:
            begin
                if (v != TAG_FMT)
                    report_status(ST_NO_FMT);
                else
                    pr_phase = PH_FMTLEN;
            end
            PH_FMTLEN:
            begin
                pr_fmt_len = v;
                pr_phase   = PH_FORMAT;
            end
            PH_FORMAT:
            begin
                if (v != FMT_PCM)
                    report_status(ST_NOT_PCM);
                else
                    pr_phase = PH_CHANNELS;
            end
            PH_CHANNELS:
            begin
                if (v != FMT_MONO)
                    report_status(ST_NOT_MONO);
                else
                    pr_phase = PH_RATE;
            end
            PH_RATE:
            begin
                pr_rate      = v;
                pr_rate_seen = 1'b1;
                pr_phase     = PH_AVG;
            end
            PH_AVG:   pr_phase = PH_ALIGN;
            PH_ALIGN: pr_phase = PH_BITS;
            PH_BITS:
            begin
                if (v != FMT_BITS)
                    report_status(ST_NOT_16BIT);
                else if (pr_fmt_len > FMT_STD_LEN)
                begin
                    begin_skip(pr_fmt_len - FMT_STD_LEN, pr_fmt_len[0]);
                    if (pr_phase == PH_CHUNKSKIP)
                        pr_phase = PH_FMTSKIP;
                end
                else
                    pr_phase = PH_CHUNKID;
            end
            PH_CHUNKID:
            begin
                pr_is_data = (v == TAG_DATA);
                pr_phase   = PH_CHUNKLEN;
            end
            PH_CHUNKLEN:
            begin
                if (pr_is_data)
                    report_status(ST_WAV_OK);
                else
                    begin_skip(v, v[0]);
            end
            default: ;
        endcase
    endfunction

    // advance the model by one accepted byte
    function automatic void sniff_byte(logic [7:0] b, logic eos);
        logic [31:0] v;
        if (!pr_decided)
        begin
            if (pr_phase == PH_FMTSKIP || pr_phase == PH_CHUNKSKIP)
            begin
                if (pr_skip != 0)
                    pr_skip = pr_skip - 1;
                else
                    pr_pad = 1'b0;
                if (pr_skip == 0 && !pr_pad)
                    pr_phase = PH_CHUNKID;
            end
            else if (pr_phase != PH_IDLE)
            begin
                pr_shift = pr_shift | (32'(b) << (8 * pr_pos));
                pr_pos++;
                if (pr_pos == field_len(pr_phase))
                begin
                    v        = pr_shift;
                    pr_pos   = 0;
                    pr_shift = '0;
                    take_field(v);
                end
            end
            else
                pr_decided = 1'b1;
            // file ended before any decision
            if (eos && !pr_decided)
                report_status(ST_TRUNCATED);
        end
        if (eos)
            parser_restart();
    endfunction

    // ------------------------------------------------------------------------
    // status checker
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_q.size() == 0)
            begin
                $display("%0t: status transfer with none pending: status %0d rate %0d",
                         $time, out_data.status, out_data.file_rate);
                fail_count++;
            end
            else
            begin
                want = status_q.pop_front();
                status_seen++;
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_data.status);
                    fail_count++;
                end
                if (out_data.file_rate !== want.file_rate)
                begin
                    $display("%0t: file_rate expected %0d actual %0d",
                             $time, want.file_rate, out_data.file_rate);
                    fail_count++;
                end
                if (out_data.rate_mismatch !== want.rate_mismatch)
                begin
                    $display("%0t: rate_mismatch expected %0d actual %0d",
                             $time, want.rate_mismatch, out_data.rate_mismatch);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output stall pattern, with an optional long hold-off
    // ------------------------------------------------------------------------

    initial
    begin
        int unsigned run_left;
        bit          level;
        out_stall = 1'b0;
        run_left  = 0;
        level     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                out_stall <= 1'b0;
                level    = 1'b0;
                run_left = $urandom_range(1, 20);
            end
            else
            begin
                if (run_left == 0)
                begin
                    level    = ($urandom_range(0, 2) == 0);
                    run_left = level ? $urandom_range(1, 6) : $urandom_range(1, 30);
                end
                run_left--;
                out_stall <= level;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // offer one byte in bursts with random gaps, model it on transfer
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, end_of_stream: eos};
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        sniff_byte(b, eos);
    endtask

    // send the built file, end mark on byte cut (whole file if cut is 0)
    task automatic send_file(input int unsigned cut);
        int unsigned n;
        n = (cut == 0 || cut > file_q.size()) ? file_q.size() : cut;
        for (int unsigned i = 0; i < n; i++)
            send_byte(file_q[i], i == n - 1);
        file_q.delete();
    endtask

    // wait until every predicted status has come and the pipe is empty
    task automatic drain_results();
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_expected_rate(input logic [31:0] rate);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        do
            @(posedge clk);
        while (!cfg_ready);
        pr_expected_rate = rate;
        cfg_valid <= 1'b0;
    endtask

    task automatic file_byte(input logic [7:0] b);
        file_q.push_back(b);
    endtask

    task automatic file_half(input logic [15:0] v);
        file_byte(v[7:0]);
        file_byte(v[15:8]);
    endtask

    task automatic file_word(input logic [31:0] v);
        file_half(v[15:0]);
        file_half(v[31:16]);
    endtask

    // skipped body, capped so huge lengths end up truncated
    task automatic file_filler(input logic [31:0] len);
        int unsigned cap;
        cap = (len > 64) ? 64 : len;
        for (int unsigned i = 0; i < cap; i++)
            file_byte(8'($urandom()));
    endtask

    // riff/wave file: fmt chunk, extra chunks, data chunk and some payload
    task automatic build_wav(input logic [31:0] form, input logic [31:0] fmt_id,
                             input logic [31:0] fmt_len, input logic [15:0] fmt_code,
                             input logic [15:0] chans, input logic [31:0] rate,
                             input logic [15:0] bits, input int unsigned n_extra,
                             input logic [31:0] first_len, input int unsigned n_payload);
        logic [31:0] len;
        file_word(TAG_RIFF);
        file_word($urandom());
        file_word(form);
        file_word(fmt_id);
        file_word(fmt_len);
        file_half(fmt_code);
        file_half(chans);
        file_word(rate);
        file_word(rate << 1);
        file_half(16'd2);
        file_half(bits);
        if (fmt_len > FMT_STD_LEN)
        begin
            file_filler(fmt_len - FMT_STD_LEN);
            if (fmt_len[0])
                file_byte(8'h00);
        end
        for (int unsigned i = 0; i < n_extra; i++)
        begin
            len = (i == 0) ? first_len : 32'($urandom_range(0, 13));
            file_word((TAG_DATA ^ 32'h0000_0100) ^ ($urandom() & 32'h00FF_0000));
            file_word(len);
            file_filler(len);
            if (len[0])
                file_byte(8'h00);
        end
        file_word(TAG_DATA);
        file_word(n_payload);
        for (int unsigned i = 0; i < n_payload; i++)
            file_byte(8'($urandom()));
    endtask

    // first four bytes of the non-wave file kinds
    task automatic file_magic(input int unsigned kind);
        case (kind)
            0: file_word(TAG_NIST);
            1: file_word(TAG_OGGS);
            2: file_word(TAG_FLAC);
            3:
            begin
                file_half(MP3_LOW);
                file_byte(MP3_THIRD);
                file_byte(8'($urandom()));
            end
            4:
            begin
                file_half(MP3_LOW);
                file_byte(MP3_ALT);
                file_byte(8'($urandom()));
            end
            5:
            begin
                // mp3-like prefix with a wrong third byte
                file_half(MP3_LOW);
                file_byte(8'($urandom_range(0, 8'hFD)));
                file_byte(8'($urandom()));
            end
            6: file_word(TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)));
            default: file_word($urandom());
        endcase
    endtask

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 7))
            0: return 32'd8000;
            1: return 32'd16000;
            2: return 32'd22050;
            3: return 32'd44100;
            4: return 32'd48000;
            5: return 32'd0;
            6: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_fmt_len();
        case ($urandom_range(0, 9))
            5: return $urandom_range(17, 24);
            6: return $urandom_range(0, 15);
            7: return $urandom_range(25, 60);
            8: return 32'hFFFF_FFFF;
            9: return $urandom();
            default: return FMT_STD_LEN;
        endcase
    endfunction

    function automatic logic [31:0] pick_chunk_len();
        case ($urandom_range(0, 19))
            0: return 32'hFFFF_FFFF;
            1: return $urandom();
            default: return $urandom_range(0, 13);
        endcase
    endfunction

    // mostly the required value, sometimes anything
    function automatic logic [15:0] pick_field(logic [15:0] good);
        return ($urandom_range(0, 11) == 0) ? 16'($urandom()) : good;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every magic, decided on the fourth byte, with trailing bytes ignored
    task automatic test_magics();
        for (int unsigned k = 0; k < 8; k++)
        begin
            file_magic(k);
            for (int unsigned i = 0; i < k % 3; i++)
                file_byte(8'($urandom()));
            send_file(0);
        end
        file_word(32'hFFFF_FFFF);
        send_file(0);
        file_word(32'h0000_0000);
        file_byte(8'hFF);
        send_file(0);
    endtask

    // wave header: good file and each field fault
    task automatic test_wav_fields();
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 44100, 16, 1, 3, 4);
        send_file(0);
        build_wav(TAG_WAVE ^ 32'h1, TAG_FMT, 16, 1, 1, 44100, 16, 0, 0, 2);
        send_file(0);
        build_wav(TAG_WAVE, TAG_DATA, 16, 1, 1, 44100, 16, 0, 0, 2);
        send_file(0);
        build_wav(TAG_WAVE, TAG_FMT, 16, 16'hFFFF, 1, 44100, 16, 0, 0, 2);
        send_file(0);
        build_wav(TAG_WAVE, TAG_FMT, 16, 0, 1, 44100, 16, 0, 0, 2);
        send_file(0);
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 2, 44100, 16, 0, 0, 2);
        send_file(0);
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 44100, 16'hFFFF, 0, 0, 2);
        send_file(0);
        // short fmt length still reads the full standard body
        build_wav(TAG_WAVE, TAG_FMT, 0, 1, 1, 16000, 16, 0, 0, 2);
        send_file(0);
        // odd fmt length: extra byte plus pad
        build_wav(TAG_WAVE, TAG_FMT, 17, 1, 1, 8000, 16, 0, 0, 0);
        send_file(0);
        // even fmt extra, empty chunk then one of random length
        build_wav(TAG_WAVE, TAG_FMT, 20, 1, 1, 48000, 16, 2, 0, 3);
        send_file(0);
    endtask

    // end mark before a decision
    task automatic test_truncation();
        file_byte(8'h52);
        send_file(0);
        file_word(TAG_RIFF);
        send_file(3);
        // rate field one byte short, then fully read
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 44100, 16, 0, 0, 2);
        send_file(27);
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 44100, 16, 0, 0, 2);
        send_file(28);
        // inside the data length, then on its last byte
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 22050, 16, 0, 0, 2);
        send_file(43);
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 22050, 16, 0, 0, 2);
        send_file(44);
        // huge skip lengths run out of stream
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 32'hFFFF_FFFF, 16, 1, 32'hFFFF_FFFF, 2);
        send_file(0);
        build_wav(TAG_WAVE, TAG_FMT, 32'hFFFF_FFFF, 1, 1, 8000, 16, 0, 0, 2);
        send_file(0);
    endtask

    // matching, mismatching and unread rates under several settings
    task automatic test_expected_rate();
        set_expected_rate(32'd44100);
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 44100, 16, 0, 0, 2);
        send_file(0);
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 8000, 16, 0, 0, 2);
        send_file(0);
        build_wav(TAG_WAVE, TAG_FMT, 16, 3, 1, 8000, 16, 0, 0, 2);
        send_file(0);
        set_expected_rate(32'hFFFF_FFFF);
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 32'hFFFF_FFFF, 16, 0, 0, 2);
        send_file(0);
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 0, 16'd8, 0, 0, 2);
        send_file(0);
        set_expected_rate(32'd0);
        build_wav(TAG_WAVE, TAG_FMT, 16, 1, 1, 12345, 16, 0, 0, 2);
        send_file(0);
    endtask

    // long output hold-off while short files keep coming
    task automatic test_backpressure();
        gaps_on     = 1'b0;
        hold_cycles = 300;
        repeat (40)
        begin
            file_word(TAG_OGGS);
            send_file(0);
        end
        gaps_on = 1'b1;
    endtask

    // mostly wave files with random faults, plus magics, noise and cuts
    task automatic test_random();
        int unsigned bytes0;
        int unsigned seen0;
        int unsigned n;
        int unsigned cut;
        bytes0 = bytes_sent;
        seen0  = status_seen;
        while (bytes_sent - bytes0 < 600 || status_seen - seen0 < 15)
        begin
            if ($urandom_range(0, 9) == 0)
                set_expected_rate(pick_rate());
            gaps_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(0, 99);
            if (n < 70)
            begin
                build_wav(($urandom_range(0, 19) == 0) ? 32'($urandom()) : TAG_WAVE,
                          ($urandom_range(0, 19) == 0) ? 32'($urandom()) : TAG_FMT,
                          pick_fmt_len(), pick_field(16'd1), pick_field(16'd1),
                          pick_rate(), pick_field(16'd16), $urandom_range(0, 2),
                          pick_chunk_len(), $urandom_range(0, 6));
                n = $urandom_range(0, 6);
            end
            else if (n < 88)
            begin
                file_magic($urandom_range(0, 7));
                n = $urandom_range(0, 4);
            end
            else
                n = $urandom_range(1, 12);
            for (int unsigned i = 0; i < n; i++)
                file_byte(8'($urandom()));
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, file_q.size()) : 0;
            send_file(cut);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        in_valid         = 1'b0;
        in_data          = '0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        rst_n            = 1'b0;
        fail_count       = 0;
        status_seen      = 0;
        bytes_sent       = 0;
        burst_left       = 0;
        hold_cycles      = 0;
        gaps_on          = 1'b1;
        pr_expected_rate = '0;
        parser_restart();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_magics();
        test_wav_fields();
        test_truncation();
        test_expected_rate();
        test_backpressure();
        test_random();

        // let the last statuses come out
        in_valid <= 1'b0;
        for (int i = 0; i < 5000 && status_q.size() != 0; i++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (status_q.size() != 0)
        begin
            $display("%0t: %0d predicted status transfers never arrived",
                     $time, status_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** wav_header_sniff_parser: PASSED **");
        else
            $display("** wav_header_sniff_parser: FAILED **");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("%0t: run limit reached", $time);
        $display("** wav_header_sniff_parser: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/whps_pkg.sv
hw/rtl/whps_in_stage.sv
hw/rtl/whps_parse_core.sv
hw/rtl/whps_out_stage.sv
hw/rtl/wav_header_sniff_parser.sv
tb/wav_header_sniff_parser_tb.sv
